### hdl/tacs_pkg.sv
// tacs_pkg: shared types, constants and the solver micro-program
// used by every module of the touch affine calibration solver
// no dependencies
`default_nettype none

package tacs_pkg;

	// fixed block configuration
	localparam int POINTS    = 5;
	localparam int SAMPLES   = 3;
	localparam int RAW_BITS  = 12;

	// field widths
	localparam int COORD_W   = 12;
	localparam int DIM_W     = 12;
	localparam int KIDX_W    = 3;
	localparam int QUO_W     = 32;

	// sample collection
	localparam int SUM_W     = 14;
	localparam int SCNT_W    = 2;
	localparam int PIDX_W    = 3;
	localparam int RECIP_SH  = 17;
	localparam int RECIP_W   = 18;
	localparam int RECIP     = (2**RECIP_SH + SAMPLES - 1) / SAMPLES;
	localparam logic [COORD_W-1:0] RAW_MASK = COORD_W'((1 << RAW_BITS) - 1);

	// targets
	localparam int TGT_W      = 14;
	localparam int TGT_MARGIN = 20;

	// arithmetic widths
	localparam int OPD_W   = 33;
	localparam int PROD_W  = 2 * OPD_W;
	localparam int ACC_W   = 80;
	localparam int NUM_W   = 96;
	localparam int DEN_W   = 64;
	localparam int SPLIT   = 31;
	localparam int FRAC    = 16;
	localparam int W_S1    = 16;
	localparam int W_S2    = 28;
	localparam int W_C     = 32;
	localparam int W_D     = 64;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
	localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
	localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 12'd240;

	// input kinds
	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// output coefficient numbering
	localparam int COEF_PER_AXIS = 3;
	localparam int COEF_LAST     = 5;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] raw_x;
		logic [COORD_W-1:0] raw_y;
	} in_item_t;

	typedef struct packed {
		logic [KIDX_W-1:0]       coef_index;
		logic signed [QUO_W-1:0] coef_value;
		logic                    singular;
		logic                    last;
	} out_item_t;

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic sub;
		logic sh31;
		logic clr;
	} mac_ctl_t;

	// micro-op kinds
	localparam logic [1:0] K_MUL  = 2'd0;
	localparam logic [1:0] K_ST   = 2'd1;
	localparam logic [1:0] K_DIV  = 2'd2;
	localparam logic [1:0] K_NEXT = 2'd3;

	// operand, destination and divider source codes
	localparam int SEL_W = 6;
	localparam logic [SEL_W-1:0] SRC_ONE  = 6'd0;
	localparam logic [SEL_W-1:0] SRC_N    = 6'd1;
	localparam logic [SEL_W-1:0] SRC_RX   = 6'd2;
	localparam logic [SEL_W-1:0] SRC_RY   = 6'd3;
	localparam logic [SEL_W-1:0] SRC_U    = 6'd4;
	localparam logic [SEL_W-1:0] SRC_V    = 6'd5;
	localparam logic [SEL_W-1:0] SRC_SX   = 6'd6;
	localparam logic [SEL_W-1:0] SRC_SY   = 6'd7;
	localparam logic [SEL_W-1:0] SRC_SXX  = 6'd8;
	localparam logic [SEL_W-1:0] SRC_SYY  = 6'd9;
	localparam logic [SEL_W-1:0] SRC_SXY  = 6'd10;
	localparam logic [SEL_W-1:0] SRC_S0   = 6'd11;
	localparam logic [SEL_W-1:0] SRC_S1   = 6'd12;
	localparam logic [SEL_W-1:0] SRC_SXS0 = 6'd13;
	localparam logic [SEL_W-1:0] SRC_SXS1 = 6'd14;
	localparam logic [SEL_W-1:0] SRC_SYS0 = 6'd15;
	localparam logic [SEL_W-1:0] SRC_SYS1 = 6'd16;
	localparam logic [SEL_W-1:0] SRC_ST   = 6'd17;
	localparam logic [SEL_W-1:0] SRC_SXST = 6'd18;
	localparam logic [SEL_W-1:0] SRC_SYST = 6'd19;
	localparam logic [SEL_W-1:0] SRC_CXX  = 6'd20;
	localparam logic [SEL_W-1:0] SRC_CYY  = 6'd21;
	localparam logic [SEL_W-1:0] SRC_CXY  = 6'd22;
	localparam logic [SEL_W-1:0] SRC_CXU  = 6'd23;
	localparam logic [SEL_W-1:0] SRC_CYU  = 6'd24;
	localparam logic [SEL_W-1:0] SRC_D    = 6'd25;
	localparam logic [SEL_W-1:0] SRC_ND   = 6'd26;
	localparam logic [SEL_W-1:0] SRC_NA   = 6'd27;
	localparam logic [SEL_W-1:0] SRC_NB   = 6'd28;
	localparam logic [SEL_W-1:0] SRC_CN   = 6'd29;
	localparam logic [SEL_W-1:0] SRC_DLO  = 6'd30;
	localparam logic [SEL_W-1:0] SRC_DHI  = 6'd31;
	localparam logic [SEL_W-1:0] SRC_NALO = 6'd32;
	localparam logic [SEL_W-1:0] SRC_NAHI = 6'd33;
	localparam logic [SEL_W-1:0] SRC_NBLO = 6'd34;
	localparam logic [SEL_W-1:0] SRC_NBHI = 6'd35;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SEL_W-1:0] a_sel;
		logic [SEL_W-1:0] b_sel;
		logic             sub;
		logic             sh31;
		logic             clr;
		logic             loop;
		logic [SEL_W-1:0] dst;
	} uop_t;

	localparam int PC_W     = 6;
	localparam int T_START  = 37;
	localparam int DIV0_PC  = 56;

	function automatic uop_t u_mul(input logic [SEL_W-1:0] a, input logic [SEL_W-1:0] b,
			input logic sub, input logic sh, input logic clr, input logic loop);
		uop_t u;
		u.kind  = K_MUL;
		u.a_sel = a;
		u.b_sel = b;
		u.sub   = sub;
		u.sh31  = sh;
		u.clr   = clr;
		u.loop  = loop;
		u.dst   = SRC_ONE;
		return u;
	endfunction

	function automatic uop_t u_st(input logic [SEL_W-1:0] dst);
		uop_t u;
		u = u_mul(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b0);
		u.kind = K_ST;
		u.dst  = dst;
		return u;
	endfunction

	function automatic uop_t u_div(input logic [SEL_W-1:0] num, input logic [SEL_W-1:0] den);
		uop_t u;
		u = u_mul(num, den, 1'b0, 1'b0, 1'b0, 1'b0);
		u.kind = K_DIV;
		return u;
	endfunction

	function automatic uop_t u_next();
		uop_t u;
		u = u_mul(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b0);
		u.kind = K_NEXT;
		return u;
	endfunction

	// solver program: point sums, centred moments, determinant, then per axis
	function automatic uop_t uprog(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = u_mul(SRC_RX, SRC_ONE, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd1:  u = u_st(SRC_SX);
			6'd2:  u = u_mul(SRC_RY, SRC_ONE, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd3:  u = u_st(SRC_SY);
			6'd4:  u = u_mul(SRC_RX, SRC_RX, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd5:  u = u_st(SRC_SXX);
			6'd6:  u = u_mul(SRC_RY, SRC_RY, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd7:  u = u_st(SRC_SYY);
			6'd8:  u = u_mul(SRC_RX, SRC_RY, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd9:  u = u_st(SRC_SXY);
			6'd10: u = u_mul(SRC_U, SRC_ONE, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd11: u = u_st(SRC_S0);
			6'd12: u = u_mul(SRC_V, SRC_ONE, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd13: u = u_st(SRC_S1);
			6'd14: u = u_mul(SRC_RX, SRC_U, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd15: u = u_st(SRC_SXS0);
			6'd16: u = u_mul(SRC_RX, SRC_V, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd17: u = u_st(SRC_SXS1);
			6'd18: u = u_mul(SRC_RY, SRC_U, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd19: u = u_st(SRC_SYS0);
			6'd20: u = u_mul(SRC_RY, SRC_V, 1'b0, 1'b0, 1'b1, 1'b1);
			6'd21: u = u_st(SRC_SYS1);
			6'd22: u = u_mul(SRC_N, SRC_SXX, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd23: u = u_mul(SRC_SX, SRC_SX, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd24: u = u_st(SRC_CXX);
			6'd25: u = u_mul(SRC_N, SRC_SYY, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd26: u = u_mul(SRC_SY, SRC_SY, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd27: u = u_st(SRC_CYY);
			6'd28: u = u_mul(SRC_N, SRC_SXY, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd29: u = u_mul(SRC_SX, SRC_SY, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd30: u = u_st(SRC_CXY);
			6'd31: u = u_mul(SRC_CXX, SRC_CYY, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd32: u = u_mul(SRC_CXY, SRC_CXY, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd33: u = u_st(SRC_D);
			6'd34: u = u_mul(SRC_N, SRC_DLO, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd35: u = u_mul(SRC_N, SRC_DHI, 1'b0, 1'b1, 1'b0, 1'b0);
			6'd36: u = u_st(SRC_ND);
			6'd37: u = u_mul(SRC_N, SRC_SXST, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd38: u = u_mul(SRC_SX, SRC_ST, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd39: u = u_st(SRC_CXU);
			6'd40: u = u_mul(SRC_N, SRC_SYST, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd41: u = u_mul(SRC_SY, SRC_ST, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd42: u = u_st(SRC_CYU);
			6'd43: u = u_mul(SRC_CXU, SRC_CYY, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd44: u = u_mul(SRC_CYU, SRC_CXY, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd45: u = u_st(SRC_NA);
			6'd46: u = u_mul(SRC_CYU, SRC_CXX, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd47: u = u_mul(SRC_CXU, SRC_CXY, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd48: u = u_st(SRC_NB);
			6'd49: u = u_mul(SRC_ST, SRC_DLO, 1'b0, 1'b0, 1'b1, 1'b0);
			6'd50: u = u_mul(SRC_ST, SRC_DHI, 1'b0, 1'b1, 1'b0, 1'b0);
			6'd51: u = u_mul(SRC_NALO, SRC_SX, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd52: u = u_mul(SRC_NAHI, SRC_SX, 1'b1, 1'b1, 1'b0, 1'b0);
			6'd53: u = u_mul(SRC_NBLO, SRC_SY, 1'b1, 1'b0, 1'b0, 1'b0);
			6'd54: u = u_mul(SRC_NBHI, SRC_SY, 1'b1, 1'b1, 1'b0, 1'b0);
			6'd55: u = u_st(SRC_CN);
			6'd56: u = u_div(SRC_NA, SRC_D);
			6'd57: u = u_div(SRC_NB, SRC_D);
			6'd58: u = u_div(SRC_CN, SRC_ND);
			default: u = u_next();
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

### hdl/touch_affine_calibration_solver.sv
// touch_affine_calibration_solver: five-point least-squares affine touch calibration
// top level with sequencer and working registers; depends on tacs_pkg,
// tacs_collect, tacs_mac and tacs_div
//
//   channel  | signals                        | transfer
//   ---------+--------------------------------+---------------------------------
//   input    | in_valid, in_stall, in_data    | in_valid high, in_stall low
//   output   | out_valid, out_stall, out_data | out_valid high, out_stall low
//   config   | cfg_wen, cfg_index, cfg_wdata  | cfg_wen high
//
// the fifth target starts the solve, which runs on one shared 33x33
// multiply-accumulate unit and a one-bit-a-cycle divider (six divisions
// of 96 steps), while in_stall stays high
// results leave through an output register; out_stall holds the sequencer
// before each new coefficient is loaded
// arst_n clears progress and sets the screen size to 320 by 240
`default_nettype none

module touch_affine_calibration_solver import tacs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_ACC   = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [DIM_W-1:0]   width_q, height_q;
	logic [2:0]         state_q;
	logic [PC_W-1:0]    pc_q;
	logic [PIDX_W-1:0]  pt_q;
	logic               t_q;
	uop_t               uop;

	logic               take, solve_start;
	logic [COORD_W-1:0] rx, ry;
	logic signed [TGT_W-1:0] tu, tv, wm, hm;

	logic signed [W_S1-1:0] sx_q, sy_q, s0_q, s1_q;
	logic signed [W_S2-1:0] sxx_q, syy_q, sxy_q, sxs0_q, sxs1_q, sys0_q, sys1_q;
	logic signed [W_C-1:0]  cxx_q, cyy_q, cxy_q, cxu_q, cyu_q;
	logic signed [W_D-1:0]  d_q, nd_q, na_q, nb_q;
	logic signed [ACC_W-1:0] cn_q, acc;

	mac_ctl_t               mac_ctl;
	logic signed [OPD_W-1:0] opa, opb;
	logic                   div_start, div_busy, div_done;
	logic signed [NUM_W-1:0] div_num;
	logic signed [DEN_W-1:0] div_den;
	logic signed [QUO_W-1:0] div_quot, coef_q;
	logic [1:0]             jj;
	logic                   emit;

	logic      out_valid_q;
	out_item_t out_data_q;

	assign take     = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_SCREEN_WIDTH;
			height_q <= RST_SCREEN_HEIGHT;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tacs_collect u_collect (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (in_data),
		.rd_idx      (pt_q),
		.rd_x        (rx),
		.rd_y        (ry),
		.solve_start (solve_start)
	);

	// target of the point under the walk
	assign wm = TGT_W'(width_q) - TGT_W'(TGT_MARGIN);
	assign hm = TGT_W'(height_q) - TGT_W'(TGT_MARGIN);

	always_comb begin
		case (pt_q)
			3'd0: begin tu = TGT_W'(TGT_MARGIN); tv = TGT_W'(TGT_MARGIN); end
			3'd1: begin tu = wm;                 tv = TGT_W'(TGT_MARGIN); end
			3'd2: begin tu = TGT_W'(TGT_MARGIN); tv = hm;                 end
			3'd3: begin tu = wm;                 tv = hm;                 end
			default: begin
				tu = TGT_W'(width_q >> 1);
				tv = TGT_W'(height_q >> 1);
			end
		endcase
	end

	assign uop = uprog(pc_q);

	function automatic logic signed [OPD_W-1:0] opnd(input logic [SEL_W-1:0] sel);
		logic signed [OPD_W-1:0] r;
		case (sel)
			SRC_ONE:  r = OPD_W'(1);
			SRC_N:    r = OPD_W'(POINTS);
			SRC_RX:   r = OPD_W'(rx);
			SRC_RY:   r = OPD_W'(ry);
			SRC_U:    r = OPD_W'(tu);
			SRC_V:    r = OPD_W'(tv);
			SRC_SX:   r = OPD_W'(sx_q);
			SRC_SY:   r = OPD_W'(sy_q);
			SRC_SXX:  r = OPD_W'(sxx_q);
			SRC_SYY:  r = OPD_W'(syy_q);
			SRC_SXY:  r = OPD_W'(sxy_q);
			SRC_ST:   r = t_q ? OPD_W'(s1_q) : OPD_W'(s0_q);
			SRC_SXST: r = t_q ? OPD_W'(sxs1_q) : OPD_W'(sxs0_q);
			SRC_SYST: r = t_q ? OPD_W'(sys1_q) : OPD_W'(sys0_q);
			SRC_CXX:  r = OPD_W'(cxx_q);
			SRC_CYY:  r = OPD_W'(cyy_q);
			SRC_CXY:  r = OPD_W'(cxy_q);
			SRC_CXU:  r = OPD_W'(cxu_q);
			SRC_CYU:  r = OPD_W'(cyu_q);
			SRC_DLO:  r = OPD_W'(d_q[SPLIT-1:0]);
			SRC_DHI:  r = $signed(d_q[W_D-1:SPLIT]);
			SRC_NALO: r = OPD_W'(na_q[SPLIT-1:0]);
			SRC_NAHI: r = $signed(na_q[W_D-1:SPLIT]);
			SRC_NBLO: r = OPD_W'(nb_q[SPLIT-1:0]);
			SRC_NBHI: r = $signed(nb_q[W_D-1:SPLIT]);
			default:  r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		opa = opnd(uop.a_sel);
		opb = opnd(uop.b_sel);
	end

	assign mac_ctl.mul_en = (state_q == S_FETCH) && (uop.kind == K_MUL);
	assign mac_ctl.acc_en = (state_q == S_ACC);
	assign mac_ctl.sub    = uop.sub;
	assign mac_ctl.sh31   = uop.sh31;
	assign mac_ctl.clr    = uop.clr && (pt_q == '0);

	tacs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (opa),
		.b      (opb),
		.acc    (acc)
	);

	always_comb begin
		case (uop.a_sel)
			SRC_NA:  div_num = NUM_W'(na_q) <<< FRAC;
			SRC_NB:  div_num = NUM_W'(nb_q) <<< FRAC;
			default: div_num = NUM_W'(cn_q) <<< FRAC;
		endcase
	end

	assign div_den   = (uop.b_sel == SRC_ND) ? nd_q : d_q;
	assign div_start = (state_q == S_FETCH) && (uop.kind == K_DIV);

	tacs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// working registers
	always_ff @(posedge clk) begin
		if ((state_q == S_FETCH) && (uop.kind == K_ST)) begin
			case (uop.dst)
				SRC_SX:   sx_q   <= W_S1'(acc);
				SRC_SY:   sy_q   <= W_S1'(acc);
				SRC_SXX:  sxx_q  <= W_S2'(acc);
				SRC_SYY:  syy_q  <= W_S2'(acc);
				SRC_SXY:  sxy_q  <= W_S2'(acc);
				SRC_S0:   s0_q   <= W_S1'(acc);
				SRC_S1:   s1_q   <= W_S1'(acc);
				SRC_SXS0: sxs0_q <= W_S2'(acc);
				SRC_SXS1: sxs1_q <= W_S2'(acc);
				SRC_SYS0: sys0_q <= W_S2'(acc);
				SRC_SYS1: sys1_q <= W_S2'(acc);
				SRC_CXX:  cxx_q  <= W_C'(acc);
				SRC_CYY:  cyy_q  <= W_C'(acc);
				SRC_CXY:  cxy_q  <= W_C'(acc);
				SRC_CXU:  cxu_q  <= W_C'(acc);
				SRC_CYU:  cyu_q  <= W_C'(acc);
				SRC_D:    d_q    <= W_D'(acc);
				SRC_ND:   nd_q   <= W_D'(acc);
				SRC_NA:   na_q   <= W_D'(acc);
				SRC_NB:   nb_q   <= W_D'(acc);
				default:  cn_q   <= acc;
			endcase
		end
		if ((state_q == S_WAIT) && div_done) begin
			coef_q <= div_quot;
		end
	end

	assign emit = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign jj   = 2'(pc_q - PC_W'(DIV0_PC));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			pt_q    <= '0;
			t_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (solve_start) begin
						state_q <= S_FETCH;
						pc_q    <= '0;
						pt_q    <= '0;
						t_q     <= 1'b0;
					end
				end
				S_FETCH: begin
					case (uop.kind)
						K_MUL: state_q <= S_ACC;
						K_ST:  pc_q    <= pc_q + 1'b1;
						K_DIV: state_q <= S_WAIT;
						default: begin
							if (!t_q) begin
								t_q  <= 1'b1;
								pc_q <= PC_W'(T_START);
							end else begin
								state_q <= S_IDLE;
							end
						end
					endcase
				end
				S_ACC: begin
					state_q <= S_FETCH;
					if (uop.loop && (pt_q != PIDX_W'(POINTS - 1))) begin
						pt_q <= pt_q + 1'b1;
					end else begin
						pt_q <= '0;
						pc_q <= pc_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_FETCH;
						pc_q    <= pc_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.coef_index <= KIDX_W'(jj) + (t_q ? KIDX_W'(COEF_PER_AXIS) : '0);
			out_data_q.coef_value <= coef_q;
			out_data_q.singular   <= (d_q == '0);
			out_data_q.last       <= t_q && (jj == 2'(COEF_PER_AXIS - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef ASSERT_OFF
	a_start_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		solve_start |=> in_stall)
		else $error("input not stalled after solve start");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.singular) |-> (out_data.coef_value == '0))
		else $error("singular fit with non-zero coefficient");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.coef_index == KIDX_W'(COEF_LAST))))
		else $error("last flag does not match coefficient index");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> ($past(state_q) == S_FETCH))
		else $error("accumulate without a product");
`endif

endmodule

`default_nettype wire

### hdl/tacs_collect.sv
// tacs_collect: sample summing, averaging and the per-target point store
// depends on tacs_pkg
`default_nettype none

module tacs_collect import tacs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  in_item_t           item,
	input  logic [PIDX_W-1:0]  rd_idx,
	output logic [COORD_W-1:0] rd_x,
	output logic [COORD_W-1:0] rd_y,
	output logic               solve_start
);

	logic [SUM_W-1:0]         sum_x_q, sum_y_q;
	logic [SCNT_W-1:0]        cnt_q;
	logic [PIDX_W-1:0]        pidx_q;
	logic [2*COORD_W-1:0]     store_q [POINTS];
	logic [SUM_W-1:0]         add_x, add_y;
	logic [SUM_W+RECIP_W-1:0] px, py;
	logic [COORD_W-1:0]       avg_x, avg_y;
	logic                     sample, point_done, last_pt;

	assign add_x = sum_x_q + SUM_W'(item.raw_x & RAW_MASK);
	assign add_y = sum_y_q + SUM_W'(item.raw_y & RAW_MASK);
	assign px    = (SUM_W+RECIP_W)'(add_x) * (SUM_W+RECIP_W)'(RECIP);
	assign py    = (SUM_W+RECIP_W)'(add_y) * (SUM_W+RECIP_W)'(RECIP);
	assign avg_x = COORD_W'(px >> RECIP_SH);
	assign avg_y = COORD_W'(py >> RECIP_SH);

	assign sample      = take && (item.kind == KIND_SAMPLE);
	assign point_done  = sample && (cnt_q == SCNT_W'(SAMPLES - 1));
	assign last_pt     = (pidx_q == PIDX_W'(POINTS - 1));
	assign solve_start = point_done && last_pt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
			pidx_q  <= '0;
		end else if (take && (item.kind == KIND_RESTART)) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
			pidx_q  <= '0;
		end else if (point_done) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
			pidx_q  <= last_pt ? '0 : pidx_q + 1'b1;
		end else if (sample) begin
			sum_x_q <= add_x;
			sum_y_q <= add_y;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (point_done) begin
			store_q[pidx_q] <= {avg_x, avg_y};
		end
	end

	assign {rd_x, rd_y} = store_q[rd_idx];

endmodule

`default_nettype wire

### hdl/tacs_mac.sv
// tacs_mac: shared signed multiply-accumulate unit, product registered
// before the accumulate; depends on tacs_pkg
`default_nettype none

module tacs_mac import tacs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [OPD_W-1:0] a,
	input  logic signed [OPD_W-1:0] b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q, base, term;

	assign base = ctl.clr ? '0 : acc_q;
	assign term = ctl.sh31 ? (ACC_W'(prod_q) <<< SPLIT) : ACC_W'(prod_q);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.sub ? base - term : base + term;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### hdl/tacs_div.sv
// tacs_div: bit-serial restoring divider, signed, truncating, saturated to 32 bits
// one quotient bit per cycle; depends on tacs_pkg
`default_nettype none

module tacs_div import tacs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic                    busy,
	output logic                    done,
	output logic signed [QUO_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic              act_q, fin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  n_q;
	logic [DEN_W-1:0]  dmag_q, rem_q;
	logic [QUO_W:0]    q_q;
	logic              ovf_q, neg_q, zero_q;
	logic [DEN_W:0]    rem_sh, diff;
	logic              ge, big;

	assign rem_sh = {rem_q, n_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, dmag_q};
	assign ge     = (rem_sh >= {1'b0, dmag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (act_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					act_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dmag_q <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
			zero_q <= (den == '0);
			rem_q  <= '0;
			q_q    <= '0;
			ovf_q  <= 1'b0;
		end else if (act_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			n_q   <= n_q << 1;
			q_q   <= {q_q[QUO_W-1:0], ge};
			ovf_q <= ovf_q | q_q[QUO_W];
		end
	end

	assign big = ovf_q | q_q[QUO_W] | q_q[QUO_W-1];

	always_comb begin
		if (zero_q) begin
			quot = '0;
		end else if (big) begin
			quot = neg_q ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
		end else if (neg_q) begin
			quot = -$signed(q_q[QUO_W-1:0]);
		end else begin
			quot = $signed(q_q[QUO_W-1:0]);
		end
	end

	assign busy = act_q;
	assign done = fin_q;

endmodule

`default_nettype wire

### tb/sv/touch_affine_calibration_solver_tb.sv
// touch_affine_calibration_solver_tb: self-checking bench for the five-point touch calibration
// solver; a local predictor works out the six coefficients of each fit and checks the results
// depends on tacs_pkg and touch_affine_calibration_solver
`timescale 1ns / 1ps

module touch_affine_calibration_solver_tb;
	import tacs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 900;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [DIM_W-1:0]     cfg_wdata = '0;

	// predictor state
	int unsigned scr_w = RST_SCREEN_WIDTH;
	int unsigned scr_h = RST_SCREEN_HEIGHT;
	int unsigned avg_x [POINTS];
	int unsigned avg_y [POINTS];
	int unsigned acc_x = 0, acc_y = 0, taken = 0, target_no = 0;

	out_item_t pending_coefs [$];
	int errors = 0;
	int idle_cycles = 0;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	int stall_left = 0;

	touch_affine_calibration_solver DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint signed sat_quot(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] q;
		q = num / den;
		if (q > 128'sd2147483647)
			return 64'sd2147483647;
		if (q < -128'sd2147483648)
			return -64'sd2147483648;
		return longint'(q);
	endfunction

	function automatic void fit_coefs();
		longint signed n, sx, sy, sxx, syy, sxy, rx, ry, cxx, cyy, cxy, d, cxu, cyu, na, nb;
		longint signed s [2], sxs [2], sys [2], tg [2], val [3];
		logic signed [127:0] cn;
		out_item_t r;
		n = POINTS;
		sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
		for (int t = 0; t < 2; t++) begin
			s[t] = 0; sxs[t] = 0; sys[t] = 0;
		end
		for (int i = 0; i < POINTS; i++) begin
			rx = avg_x[i];
			ry = avg_y[i];
			case (i)
				0: begin tg[0] = 20; tg[1] = 20; end
				1: begin tg[0] = longint'(scr_w) - 20; tg[1] = 20; end
				2: begin tg[0] = 20; tg[1] = longint'(scr_h) - 20; end
				3: begin tg[0] = longint'(scr_w) - 20; tg[1] = longint'(scr_h) - 20; end
				default: begin tg[0] = longint'(scr_w) / 2; tg[1] = longint'(scr_h) / 2; end
			endcase
			sx += rx; sy += ry;
			sxx += rx * rx; syy += ry * ry; sxy += rx * ry;
			for (int t = 0; t < 2; t++) begin
				s[t] += tg[t]; sxs[t] += rx * tg[t]; sys[t] += ry * tg[t];
			end
		end
		cxx = n * sxx - sx * sx;
		cyy = n * syy - sy * sy;
		cxy = n * sxy - sx * sy;
		d = cxx * cyy - cxy * cxy;
		for (int t = 0; t < 2; t++) begin
			cxu = n * sxs[t] - sx * s[t];
			cyu = n * sys[t] - sy * s[t];
			na = cxu * cyy - cyu * cxy;
			nb = cyu * cxx - cxu * cxy;
			val[0] = 0; val[1] = 0; val[2] = 0;
			if (d != 0) begin
				val[0] = sat_quot(128'(na) <<< 16, 128'(d));
				val[1] = sat_quot(128'(nb) <<< 16, 128'(d));
				cn = 128'(s[t]) * 128'(d) - 128'(na) * 128'(sx) - 128'(nb) * 128'(sy);
				val[2] = sat_quot(cn <<< 16, 128'(n) * 128'(d));
			end
			for (int i = 0; i < COEF_PER_AXIS; i++) begin
				r.coef_index = KIDX_W'(t * COEF_PER_AXIS + i);
				r.coef_value = val[i][31:0];
				r.singular   = (d == 0);
				r.last       = (t * COEF_PER_AXIS + i == COEF_LAST);
				pending_coefs.push_back(r);
			end
		end
	endfunction

	function automatic void predict_item(input in_item_t it);
		if (it.kind == KIND_RESTART) begin
			acc_x = 0; acc_y = 0; taken = 0; target_no = 0;
			return;
		end
		acc_x += it.raw_x & RAW_MASK;
		acc_y += it.raw_y & RAW_MASK;
		taken++;
		if (taken < SAMPLES)
			return;
		avg_x[target_no] = acc_x / SAMPLES;
		avg_y[target_no] = acc_y / SAMPLES;
		acc_x = 0; acc_y = 0; taken = 0;
		target_no++;
		if (target_no < POINTS)
			return;
		target_no = 0;
		fit_coefs();
	endfunction

	task automatic send_item(input logic kind, input int unsigned x, input int unsigned y);
		int gap;
		in_item_t it;
		gap = send_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.kind = kind;
		it.raw_x = COORD_W'(x);
		it.raw_y = COORD_W'(y);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		predict_item(it);
	endtask

	task automatic send_point(input int unsigned x, input int unsigned y, input int spread);
		for (int k = 0; k < SAMPLES; k++)
			send_item(KIND_SAMPLE, (x + $urandom_range(0, spread)) % 4096,
				(y + $urandom_range(0, spread)) % 4096);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_coefs.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= DIM_W'(v);
		@(posedge clk);
		if (idx == REG_SCREEN_WIDTH)
			scr_w = v;
		else
			scr_h = v;
	endtask

	task automatic set_screen(input int unsigned w, input int unsigned h);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		cfg_wen <= 1'b0;
	endtask

	task automatic test_default_screen();
		send_point(100, 120, 3);
		send_point(3900, 140, 3);
		send_point(120, 3800, 3);
		send_point(3850, 3900, 3);
		send_point(2000, 2000, 3);
		drain();
	endtask

	task automatic test_raw_extremes();
		set_screen(4095, 4095);
		send_point(0, 0, 0);
		send_point(4095, 0, 0);
		send_point(0, 4095, 0);
		send_point(4095, 4095, 0);
		send_item(KIND_SAMPLE, 4095, 0);
		send_item(KIND_SAMPLE, 0, 4095);
		send_item(KIND_SAMPLE, 2048, 2047);
		drain();
	endtask

	task automatic test_restart();
		set_screen(48, 48);
		send_point(500, 600, 10);
		send_item(KIND_SAMPLE, 7, 9);
		send_item(KIND_RESTART, 4095, 4095);
		send_point(10, 20, 2);
		send_point(4000, 30, 2);
		send_point(40, 4000, 2);
		send_point(4010, 4020, 2);
		send_point(2000, 2100, 2);
		drain();
	endtask

	task automatic test_singular();
		set_screen(320, 240);
		for (int p = 0; p < POINTS; p++)
			send_point(1234, 2345, 0);
		for (int p = 0; p < POINTS; p++)
			send_point(100 * p, 200 * p, 0);
		drain();
	endtask

	task automatic test_random();
		int run_pts;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_screen(48, 4095);
				1: set_screen(4095, 48);
				default: set_screen($urandom_range(48, 4095), $urandom_range(48, 4095));
			endcase
			send_gaps = (phase != 2);
			recv_gaps = (phase != 3);
			for (int run = 0; run < 4; run++) begin
				run_pts = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : POINTS;
				for (int p = 0; p < run_pts; p++) begin
					if ($urandom_range(0, 7) == 0)
						send_point($urandom_range(0, 4095), $urandom_range(0, 4095), 0);
					else
						send_point($urandom_range(0, 4095), $urandom_range(0, 4095),
							$urandom_range(0, 40));
				end
				if (run_pts < POINTS || $urandom_range(0, 9) == 0)
					send_item(KIND_RESTART, $urandom_range(0, 4095), $urandom_range(0, 4095));
			end
			drain();
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_coefs.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				if (out_data.coef_index !== pending_coefs[0].coef_index) begin
					$display("%0t: coef_index expected %0d actual %0d", $time,
						pending_coefs[0].coef_index, out_data.coef_index);
					errors++;
				end
				if (out_data.coef_value !== pending_coefs[0].coef_value) begin
					$display("%0t: coef_value expected %0d actual %0d", $time,
						pending_coefs[0].coef_value, out_data.coef_value);
					errors++;
				end
				if (out_data.singular !== pending_coefs[0].singular) begin
					$display("%0t: singular expected %0b actual %0b", $time,
						pending_coefs[0].singular, out_data.singular);
					errors++;
				end
				if (out_data.last !== pending_coefs[0].last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						pending_coefs[0].last, out_data.last);
					errors++;
				end
				void'(pending_coefs.pop_front());
			end
			stall_left = recv_gaps ? $urandom_range(0, 9) : 0;
		end
		out_stall <= (stall_left > 0);
		if (stall_left > 0)
			stall_left--;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_screen();
		test_raw_extremes();
		test_restart();
		test_singular();
		test_random();
		if (errors == 0 && pending_coefs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
